>>> rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// Used by the front end, probe engine and top level; it depends on nothing else.
package lpht_pkg;

  localparam int CFG_W      = 9;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 8;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 9'd50;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  // Classification that travels with every queued request.
  typedef struct packed {
    op_t  op;
    logic bad;
  } lpht_ctrl_t;

endpackage

>>> rtl/lpht_mod.sv
// Iterative remainder unit: one dividend bit per cycle (restoring method).
// Computes the home slot of a key; no package dependency.
module lpht_mod #(
  parameter int KEY_BITS = 31,
  parameter int SLOT_W   = 8,
  parameter int NW       = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] dividend,
  input  logic [NW-1:0]       divisor,
  output logic                busy,
  output logic [SLOT_W-1:0]   remainder
);

  localparam int CW = $clog2(KEY_BITS + 1);

  logic [CW-1:0]       cnt;
  logic [KEY_BITS-1:0] dvd;
  logic [NW-1:0]       rem;
  logic [NW:0]         rem_shift;
  logic [NW-1:0]       rem_next;

  // The partial remainder stays below the divisor, so the shifted value
  // is below twice the divisor and one subtract is enough.
  always_comb begin
    rem_shift = {rem, dvd[KEY_BITS-1]};
    if (rem_shift >= {1'b0, divisor}) begin
      rem_next = NW'(rem_shift - {1'b0, divisor});
    end else begin
      rem_next = NW'(rem_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(KEY_BITS);
      rem  <= '0;
      dvd  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign remainder = rem[SLOT_W-1:0];

endmodule

>>> rtl/lpht_front.sv
// Front end: takes request transfers, flags zero keys and hashes both keys.
// Depends on lpht_pkg and lpht_mod; feeds the request queue.
module lpht_front #(
  parameter int KEY_BITS = 31,
  parameter int SLOT_W   = 8,
  parameter int NW       = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [NW-1:0]       n,
  input  logic                init_done,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          req_type,
  input  logic [KEY_BITS-1:0] key,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic                q_full,
  output logic                q_push,
  output lpht_pkg::lpht_ctrl_t q_ctrl,
  output logic [KEY_BITS-1:0] q_key,
  output logic [KEY_BITS-1:0] q_new_key,
  output logic [SLOT_W-1:0]   q_home,
  output logic [SLOT_W-1:0]   q_new_home
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t state;
  logic    accept;
  logic    bad_in;
  logic    hash_start;
  logic    busy_a;
  logic    busy_b;

  assign req_stall  = (state != F_IDLE) || !init_done;
  assign accept     = req_valid && !req_stall;
  assign bad_in     = (key == '0) || ((op_t'(req_type) == OP_UPDATE) && (new_key == '0));
  assign hash_start = accept && !bad_in;
  assign q_push     = (state == F_PUSH) && !q_full;

  lpht_mod #(.KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W), .NW(NW)) u_mod_key (
    .clk(clk), .rst(rst), .start(hash_start), .dividend(key), .divisor(n),
    .busy(busy_a), .remainder(q_home)
  );

  lpht_mod #(.KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W), .NW(NW)) u_mod_new (
    .clk(clk), .rst(rst), .start(hash_start), .dividend(new_key), .divisor(n),
    .busy(busy_b), .remainder(q_new_home)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            q_ctrl.op  <= op_t'(req_type);
            q_ctrl.bad <= bad_in;
            q_key      <= key;
            q_new_key  <= new_key;
            state      <= bad_in ? F_PUSH : F_HASH;
          end
        end
        F_HASH: begin
          if (!busy_a && !busy_b) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/lpht_queue.sv
// Two-entry queue between the front end and the probe engine.
// Carries packed request words; no package dependency.
module lpht_queue #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

>>> rtl/lpht_back.sv
// Probe engine: owns the slot memory, walks the probe sequence and
// holds the result register. Depends on lpht_pkg.
module lpht_back #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 31,
  parameter int SLOT_W    = 8,
  parameter int NW        = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [NW-1:0]          n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  lpht_pkg::lpht_ctrl_t   q_ctrl,
  input  logic [KEY_BITS-1:0]    q_key,
  input  logic [KEY_BITS-1:0]    q_new_key,
  input  logic [SLOT_W-1:0]      q_home,
  input  logic [SLOT_W-1:0]      q_new_home,
  output logic                   init_done,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK, B_RESP} bstate_t;

  bstate_t             state;
  op_t                 op;
  logic [KEY_BITS-1:0] cur_key;
  logic [KEY_BITS-1:0] new_key_q;
  logic [SLOT_W-1:0]   new_home_q;
  logic [SLOT_W-1:0]   at;
  logic [NW-1:0]       cnt;
  logic                put_phase;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;

  logic [KEY_BITS-1:0] mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] rdata;
  logic                mem_we;
  logic [KEY_BITS-1:0] mem_wdata;

  logic                hit;
  logic                empty_slot;
  logic                last;
  logic [SLOT_W-1:0]   at_inc;
  logic [SLOT_OUT_W+SLOT_W-1:0] slot_ext;

  assign q_pop      = (state == B_IDLE) && !q_empty;
  assign init_done  = (state != B_CLEAR);
  assign hit        = (rdata == cur_key);
  assign empty_slot = (rdata == '0);
  assign last       = ((cnt + NW'(1)) == n);
  assign at_inc     = ((NW'(at) + NW'(1)) == n) ? '0 : at + SLOT_W'(1);
  assign slot_ext   = {{SLOT_OUT_W{1'b0}}, res_slot};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state)
      B_CLEAR: mem_we = 1'b1;
      B_CHECK: begin
        if (hit && !put_phase && (op == OP_REMOVE || op == OP_UPDATE)) begin
          mem_we = 1'b1;
        end else if (!hit && put_phase && empty_slot) begin
          mem_we    = 1'b1;
          mem_wdata = cur_key;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[at] <= mem_wdata;
    end
    rdata <= mem[at];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      at        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In B_RESP a new result takes the place of one leaving in the same cycle.
      if (rsp_valid && !rsp_stall && (state != B_RESP)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        // One slot is zeroed per cycle after reset.
        B_CLEAR: begin
          if (at == SLOT_W'(MAX_SLOTS - 1)) begin
            at    <= '0;
            state <= B_IDLE;
          end else begin
            at <= at + SLOT_W'(1);
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            op         <= q_ctrl.op;
            cur_key    <= q_key;
            new_key_q  <= q_new_key;
            new_home_q <= q_new_home;
            at         <= q_home;
            cnt        <= '0;
            put_phase  <= (q_ctrl.op == OP_INSERT);
            if (q_ctrl.bad) begin
              res_status <= ST_INVALID;
              res_slot   <= '0;
              state      <= B_RESP;
            end else begin
              state <= B_READ;
            end
          end
        end
        B_READ: state <= B_CHECK;
        B_CHECK: begin
          if (hit) begin
            if (put_phase) begin
              res_status <= ST_PRESENT;
              res_slot   <= at;
              state      <= B_RESP;
            end else if (op == OP_UPDATE) begin
              // Old key is removed this cycle; insert the new key from its home.
              put_phase <= 1'b1;
              cur_key   <= new_key_q;
              at        <= new_home_q;
              cnt       <= '0;
              state     <= B_READ;
            end else begin
              res_status <= ST_DONE;
              res_slot   <= at;
              state      <= B_RESP;
            end
          end else if (put_phase && empty_slot) begin
            res_status <= ST_DONE;
            res_slot   <= at;
            state      <= B_RESP;
          end else if (last) begin
            res_status <= put_phase ? ST_FULL : ST_NOT_FOUND;
            res_slot   <= '0;
            state      <= B_RESP;
          end else begin
            at    <= at_inc;
            cnt   <= cnt + NW'(1);
            state <= B_READ;
          end
        end
        B_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            status    <= res_status;
            slot      <= slot_ext[SLOT_OUT_W-1:0];
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/linear_probe_hash_table.sv
// Linear probing hash table, top level: size register, front end, queue, probe engine.
// Path to a result: the front end hashes a request into the queue, the probe engine
// pops it, reads and checks each probed slot in turn, loads the result register and
// transfers it. A zero key skips hashing and probing; an update probes for the old
// key, then from the new key's home. The front end takes no new request until it has
// pushed the last. Reset (synchronous) clears all MAX_SLOTS slots with req_stall high.
module linear_probe_hash_table #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lpht_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      req_type,
  input  logic [KEY_BITS-1:0]             key,
  input  logic [KEY_BITS-1:0]             new_key,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot
);
  import lpht_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int NW     = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (NW > CFG_W) ? NW : CFG_W;
  localparam int QW     = $bits(lpht_ctrl_t) + 2 * KEY_BITS + 2 * SLOT_W;

  logic [CFG_W-1:0]    table_size;
  logic [CMP_W-1:0]    size_ext;
  logic [NW-1:0]       n;
  logic                init_done;

  lpht_ctrl_t          f_ctrl;
  logic [KEY_BITS-1:0] f_key;
  logic [KEY_BITS-1:0] f_new_key;
  logic [SLOT_W-1:0]   f_home;
  logic [SLOT_W-1:0]   f_new_home;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [QW-1:0]       q_rd;

  lpht_ctrl_t          b_ctrl;
  logic [KEY_BITS-1:0] b_key;
  logic [KEY_BITS-1:0] b_new_key;
  logic [SLOT_W-1:0]   b_home;
  logic [SLOT_W-1:0]   b_new_home;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  // A size of zero acts as one slot; sizes past the memory clamp to its depth.
  always_comb begin
    size_ext = CMP_W'(table_size);
    if (size_ext == '0) begin
      n = NW'(1);
    end else if (size_ext > CMP_W'(MAX_SLOTS)) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = NW'(size_ext);
    end
  end

  lpht_front #(.KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W), .NW(NW)) u_front (
    .clk(clk), .rst(rst), .n(n), .init_done(init_done),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .key(key), .new_key(new_key),
    .q_full(q_full), .q_push(q_push), .q_ctrl(f_ctrl), .q_key(f_key),
    .q_new_key(f_new_key), .q_home(f_home), .q_new_home(f_new_home)
  );

  lpht_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push),
    .wr_data({f_ctrl, f_key, f_new_key, f_home, f_new_home}),
    .pop(q_pop), .rd_data(q_rd), .full(q_full), .empty(q_empty)
  );

  assign {b_ctrl, b_key, b_new_key, b_home, b_new_home} = q_rd;

  lpht_back #(
    .MAX_SLOTS(MAX_SLOTS), .KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W), .NW(NW)
  ) u_back (
    .clk(clk), .rst(rst), .n(n), .q_empty(q_empty), .q_pop(q_pop),
    .q_ctrl(b_ctrl), .q_key(b_key), .q_new_key(b_new_key), .q_home(b_home),
    .q_new_home(b_new_home), .init_done(init_done),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .slot(slot)
  );

endmodule
